@@ hw/rtl/fbat_pkg.sv @@
// shared types and constants for the flow byte accumulator table
`default_nettype none

package fbat_pkg;

    localparam int FLOW_ENTRIES_DEF = 16;

    localparam int ADDR_W   = 16;
    localparam int OCTET_W  = 32;
    localparam int BYTES_W  = 16;
    localparam int SEQ_W    = 32;
    localparam int RTOTAL_W = 5;

    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_EXPORT  = 1'b1;

    localparam logic [SEQ_W-1:0] SEQ_RESET = 32'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]  key;
        logic [ADDR_W-1:0]  dst;
        logic [OCTET_W-1:0] octets;
    } flow_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EX_READ,
        ST_EX_LOAD,
        ST_EX_MARK
    } fbat_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/fbat_flow_mem.sv @@
// flow entry memory, one write port and one registered read port
`default_nettype none

module fbat_flow_mem #(
    parameter int FLOW_ENTRIES = fbat_pkg::FLOW_ENTRIES_DEF,
    parameter int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire fbat_pkg::flow_entry_t wr_data,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output fbat_pkg::flow_entry_t     rd_data
);
    import fbat_pkg::*;

    flow_entry_t mem_array [FLOW_ENTRIES];
    flow_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fbat_key_match.sv @@
// source key registers with parallel compare against live entries
`default_nettype none

module fbat_key_match #(
    parameter int FLOW_ENTRIES = fbat_pkg::FLOW_ENTRIES_DEF,
    parameter int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1,
    parameter int CNT_W        = $clog2(FLOW_ENTRIES + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [IDX_W-1:0]            wr_idx,
    input  wire logic [fbat_pkg::ADDR_W-1:0] wr_key,
    input  wire logic [fbat_pkg::ADDR_W-1:0] lookup_key,
    input  wire logic [CNT_W-1:0]            live_count,
    output logic                             hit,
    output logic [IDX_W-1:0]                 hit_idx
);
    import fbat_pkg::*;

    logic [ADDR_W-1:0]       key_reg [FLOW_ENTRIES];
    logic [FLOW_ENTRIES-1:0] hit_vec;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg[wr_idx] <= wr_key;
        end
    end

    // keys are unique among live entries, so at most one bit is set
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < FLOW_ENTRIES; i++)
        begin
            hit_vec[i] = (CNT_W'(i) < live_count) && (key_reg[i] == lookup_key);
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        hit = |hit_vec;
    end

endmodule

`default_nettype wire

@@ hw/rtl/flow_byte_accumulator_table.sv @@
// flow byte accumulator table top level
// observe request: a new or dropped flow completes in the idle state; a hit
//   reads the entry memory, then does a saturating add and write back
// export request: each record passes through the entry memory read port,
//   an empty table gives a marker instead; result held in an output register
// reset clears the entry count and sets the export sequence to one;
//   entry memory contents are not cleared
`default_nettype none

module flow_byte_accumulator_table #(
    parameter int FLOW_ENTRIES = fbat_pkg::FLOW_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          action,
    input  wire logic [fbat_pkg::ADDR_W-1:0]   src_addr,
    input  wire logic [fbat_pkg::ADDR_W-1:0]   dst_addr,
    input  wire logic [fbat_pkg::BYTES_W-1:0]  byte_count,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic                               is_record,
    output logic [fbat_pkg::ADDR_W-1:0]        flow_src,
    output logic [fbat_pkg::ADDR_W-1:0]        flow_dst,
    output logic [fbat_pkg::OCTET_W-1:0]       octet_total,
    output logic [fbat_pkg::SEQ_W-1:0]         export_seq,
    output logic [fbat_pkg::RTOTAL_W-1:0]      record_total,
    output logic                               last
);
    import fbat_pkg::*;

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

    fbat_state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   upd_idx_reg, upd_idx_next;
    logic [BYTES_W-1:0] upd_bytes_reg, upd_bytes_next;

    logic                res_valid_reg, res_valid_next;
    logic                is_record_reg, is_record_next;
    logic [ADDR_W-1:0]   flow_src_reg, flow_src_next;
    logic [ADDR_W-1:0]   flow_dst_reg, flow_dst_next;
    logic [OCTET_W-1:0]  octet_total_reg, octet_total_next;
    logic [SEQ_W-1:0]    export_seq_reg, export_seq_next;
    logic [RTOTAL_W-1:0] record_total_reg, record_total_next;
    logic                last_reg, last_next;

    logic              req_accept;
    logic              res_free;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              has_room;
    logic [CNT_W-1:0]  idx_inc;
    logic              idx_is_last;

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    flow_entry_t       mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    flow_entry_t       mem_rd_data;
    logic              key_wr_en;

    logic              obs_insert;
    logic              obs_hit;
    logic              load_record;
    logic              load_marker;
    logic              export_done;

    logic [OCTET_W:0]   octet_sum;
    logic [OCTET_W-1:0] octet_sat;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign res_free   = !res_valid_reg || !res_stall;
    assign has_room   = (count_reg < CNT_W'(FLOW_ENTRIES));
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_is_last = (idx_inc == count_reg);

    assign octet_sum = {1'b0, mem_rd_data.octets} + (OCTET_W + 1)'(upd_bytes_reg);
    assign octet_sat = octet_sum[OCTET_W] ? '1 : octet_sum[OCTET_W-1:0];

    fbat_key_match #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_key_match (
        .clk        (clk),
        .wr_en      (key_wr_en),
        .wr_idx     (count_reg[IDX_W-1:0]),
        .wr_key     (src_addr),
        .lookup_key (src_addr),
        .live_count (count_reg),
        .hit        (hit),
        .hit_idx    (hit_idx)
    );

    fbat_flow_mem #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_flow_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (action == ACT_EXPORT)
                    begin
                        state_next = (count_reg == '0) ? ST_EX_MARK : ST_EX_READ;
                    end
                    else if (hit)
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            ST_EX_READ:
            begin
                state_next = ST_EX_LOAD;
            end
            ST_EX_LOAD:
            begin
                if (res_free)
                begin
                    state_next = idx_is_last ? ST_IDLE : ST_EX_READ;
                end
            end
            ST_EX_MARK:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        obs_insert  = 1'b0;
        obs_hit     = 1'b0;
        load_record = 1'b0;
        load_marker = 1'b0;
        export_done = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = count_reg[IDX_W-1:0];
        mem_wr_data = '{key: src_addr, dst: dst_addr, octets: OCTET_W'(byte_count)};
        mem_rd_en   = 1'b0;
        mem_rd_addr = hit_idx;
        key_wr_en   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (action == ACT_OBSERVE))
                begin
                    if (hit)
                    begin
                        obs_hit   = 1'b1;
                        mem_rd_en = 1'b1;
                    end
                    else if (has_room)
                    begin
                        obs_insert = 1'b1;
                        mem_wr_en  = 1'b1;
                        key_wr_en  = 1'b1;
                    end
                end
            end
            ST_UPDATE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = upd_idx_reg;
                mem_wr_data = '{key: mem_rd_data.key, dst: mem_rd_data.dst,
                                octets: octet_sat};
            end
            ST_EX_READ:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg[IDX_W-1:0];
            end
            ST_EX_LOAD:
            begin
                if (res_free)
                begin
                    load_record = 1'b1;
                    export_done = idx_is_last;
                end
            end
            ST_EX_MARK:
            begin
                if (res_free)
                begin
                    load_marker = 1'b1;
                    export_done = 1'b1;
                end
            end
            default:
            begin
                obs_insert = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next        = count_reg;
        seq_next          = seq_reg;
        idx_next          = idx_reg;
        upd_idx_next      = upd_idx_reg;
        upd_bytes_next    = upd_bytes_reg;
        res_valid_next    = res_valid_reg && res_stall;
        is_record_next    = is_record_reg;
        flow_src_next     = flow_src_reg;
        flow_dst_next     = flow_dst_reg;
        octet_total_next  = octet_total_reg;
        export_seq_next   = export_seq_reg;
        record_total_next = record_total_reg;
        last_next         = last_reg;

        if (obs_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (obs_hit)
        begin
            upd_idx_next   = hit_idx;
            upd_bytes_next = byte_count;
        end
        if (req_accept && (action == ACT_EXPORT))
        begin
            idx_next = '0;
        end
        if (load_record)
        begin
            res_valid_next    = 1'b1;
            is_record_next    = 1'b1;
            flow_src_next     = mem_rd_data.key;
            flow_dst_next     = mem_rd_data.dst;
            octet_total_next  = mem_rd_data.octets;
            export_seq_next   = seq_reg;
            record_total_next = RTOTAL_W'(count_reg);
            last_next         = idx_is_last;
            idx_next          = idx_inc;
        end
        if (load_marker)
        begin
            res_valid_next    = 1'b1;
            is_record_next    = 1'b0;
            flow_src_next     = '0;
            flow_dst_next     = '0;
            octet_total_next  = '0;
            export_seq_next   = seq_reg;
            record_total_next = '0;
            last_next         = 1'b1;
        end
        if (export_done)
        begin
            count_next = '0;
            seq_next   = seq_reg + SEQ_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            seq_reg       <= SEQ_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            seq_reg       <= seq_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        upd_idx_reg      <= upd_idx_next;
        upd_bytes_reg    <= upd_bytes_next;
        is_record_reg    <= is_record_next;
        flow_src_reg     <= flow_src_next;
        flow_dst_reg     <= flow_dst_next;
        octet_total_reg  <= octet_total_next;
        export_seq_reg   <= export_seq_next;
        record_total_reg <= record_total_next;
        last_reg         <= last_next;
    end

    assign res_valid    = res_valid_reg;
    assign is_record    = is_record_reg;
    assign flow_src     = flow_src_reg;
    assign flow_dst     = flow_dst_reg;
    assign octet_total  = octet_total_reg;
    assign export_seq   = export_seq_reg;
    assign record_total = record_total_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
